// ===== hdl/tfj_pkg.sv =====
package tfj_pkg;

  // Widest line and the most words a line can hold.
  localparam int MAX_WIDTH = 64;
  localparam int MAX_WORDS = 32;

  // Character buffer: one pending line plus one word in flight.
  localparam int BUF_DEPTH = 2 * MAX_WIDTH;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);

  // Depth of the request queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [6:0] WIDTH_RESET = 7'd16;

  // One classified input character as handed from the front to the back.
  typedef struct packed {
    logic [7:0] ch;     // character code
    logic       keep;   // character lies within the line width
    logic [5:0] idx;    // position of the character in its word
    logic       wend;   // character closes a word
    logic       tend;   // character closes the text
    logic [6:0] len;    // saturated word length, valid with wend
  } tfj_req_t;

  // Clamp the programmed width to the supported range.
  function automatic logic [6:0] eff_width(input logic [6:0] lw);
    logic [6:0] res;
    res = lw;
    if (lw == 7'd0) begin
      res = 7'd1;
    end else if (lw > 7'(MAX_WIDTH)) begin
      res = 7'(MAX_WIDTH);
    end
    return res;
  endfunction

endpackage

// ===== hdl/tfj_ram.sv =====
module tfj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Single write port and a registered read port that holds when idle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/tfj_front.sv =====
module tfj_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [6:0]         width,
  input  logic               accept,
  input  logic [7:0]         char_code,
  input  logic               word_end,
  input  logic               text_end,
  output tfj_pkg::tfj_req_t  req
);

  logic [6:0] cwl_r, cwl_nxt;
  logic       keep;
  logic [6:0] cwl_inc;
  logic       close;

  // Decide whether the character fits and track the running word length.
  always_comb begin
    keep     = (cwl_r < width);
    cwl_inc  = keep ? cwl_r + 7'd1 : cwl_r;
    close    = word_end | text_end;
    cwl_nxt  = cwl_r;
    if (accept) begin
      cwl_nxt = close ? 7'd0 : cwl_inc;
    end
    req.ch   = char_code;
    req.keep = keep;
    req.idx  = cwl_r[5:0];
    req.wend = close;
    req.tend = text_end;
    req.len  = (cwl_inc > width) ? width : cwl_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cwl_r <= 7'd0;
    end else begin
      cwl_r <= cwl_nxt;
    end
  end

endmodule

// ===== hdl/tfj_req_queue.sv =====
module tfj_req_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tfj_pkg::tfj_req_t push_req,
  output logic              full,
  output logic              valid,
  output tfj_pkg::tfj_req_t head,
  input  logic              take
);

  tfj_pkg::tfj_req_t             ent_r [tfj_pkg::QDEPTH];
  logic [tfj_pkg::QPTR_W-1:0]    wp_r, rp_r;
  logic [tfj_pkg::QPTR_W:0]      cnt_r;
  logic                          do_push, do_take;

  assign full    = (cnt_r == (tfj_pkg::QPTR_W+1)'(tfj_pkg::QDEPTH));
  assign valid   = (cnt_r != '0);
  assign head    = ent_r[rp_r];
  assign do_push = push && !full;
  assign do_take = take && valid;

  // Storage for queued requests.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_req;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_take) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (tfj_pkg::QPTR_W+1)'(do_push) - (tfj_pkg::QPTR_W+1)'(do_take);
    end
  end

endmodule

// ===== hdl/tfj_back.sv =====
module tfj_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [6:0]        width,
  input  logic              req_valid,
  input  tfj_pkg::tfj_req_t req,
  output logic              req_take,
  output logic              out_valid,
  input  logic              out_take,
  output logic [63:0]       chunk,
  output logic [3:0]        chunk_bytes,
  output logic              line_end,
  output logic              text_done
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV   = 4'b0010,
    ST_START = 4'b0100,
    ST_EMIT  = 4'b1000
  } back_st_t;

  back_st_t st_r, st_nxt;

  // Line bookkeeping.
  logic [5:0] n_r, n_nxt;
  logic [6:0] used_r, used_nxt;
  logic [6:0] lens_r [tfj_pkg::MAX_WORDS];
  logic       lens_we;
  logic [4:0] lens_wa;
  logic [6:0] lens_wd;
  logic [tfj_pkg::BUF_AW-1:0] line_start_r, line_start_nxt;
  logic [tfj_pkg::BUF_AW-1:0] word_start_r, word_start_nxt;

  // Pending work after a line is flushed.
  logic       final_r, final_nxt;
  logic       add_pend_r, add_pend_nxt;
  logic       te_pend_r, te_pend_nxt;
  logic [6:0] pend_len_r, pend_len_nxt;

  // Spare-space divider.
  logic [2:0] div_cnt_r, div_cnt_nxt;
  logic [5:0] dq_r, dq_nxt;
  logic [5:0] rem_r, rem_nxt;
  logic [4:0] dvs_r, dvs_nxt;
  logic [5:0] q_r, q_nxt;
  logic [4:0] r_r, r_nxt;
  logic [5:0] rem_sh;
  logic       q_bit;

  // Line walker.
  logic [6:0] len_r, len_nxt;
  logic [6:0] pos_r, pos_nxt;
  logic [5:0] k_r, k_nxt;
  logic [6:0] crem_r, crem_nxt;
  logic [6:0] grem_r, grem_nxt;
  logic [tfj_pkg::BUF_AW-1:0] rd_ptr_r, rd_ptr_nxt;

  // Chunk assembly stage.
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_char_r, s1_char_nxt;
  logic [2:0] s1_bidx_r, s1_bidx_nxt;
  logic       s1_last_r, s1_last_nxt;
  logic       s1_final_r, s1_final_nxt;
  logic [63:0] chunk_r, chunk_nxt;

  // Output register.
  logic        ov_r, ov_nxt;
  logic [63:0] oc_r, oc_nxt;
  logic [3:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;
  logic        ot_r, ot_nxt;

  // Buffer ports.
  logic                       wr_en, rd_en;
  logic [tfj_pkg::BUF_AW-1:0] wr_addr;
  logic [7:0]                 rd_data;

  logic [6:0] len_line_c;
  logic [7:0] need_c;
  logic       fit_fail;
  logic [6:0] spare_c;
  logic [5:0] k_inc;
  logic [6:0] gap_c;
  logic       stall;
  logic       s1_done;
  logic       is_char;
  logic       last_slot;
  logic [7:0] byte_c;

  tfj_ram #(
    .WIDTH (8),
    .DEPTH (tfj_pkg::BUF_DEPTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (req.ch),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (rd_data)
  );

  // Common terms for the line decision and the walker.
  always_comb begin
    len_line_c = (used_r > width) ? used_r : width;
    need_c     = {1'b0, used_r} + 8'd1 + {1'b0, req.len};
    fit_fail   = (n_r != 6'd0) && (need_c > {1'b0, width});
    spare_c    = len_line_c - used_r;
    k_inc      = k_r + 6'd1;
    gap_c      = final_r ? 7'd1
               : 7'd1 + {1'b0, q_r} + {6'd0, (k_r < {1'b0, r_r})};
    s1_done    = s1_valid_r && ((s1_bidx_r == 3'd7) || s1_last_r);
    stall      = s1_done && ov_r && !out_take;
    is_char    = (crem_r != 7'd0);
    last_slot  = (pos_r == len_r - 7'd1);
    rem_sh     = {rem_r[4:0], dq_r[5]};
    q_bit      = (rem_sh >= {1'b0, dvs_r});
  end

  // Sequencer: takes requests, divides, and walks the pending line.
  always_comb begin
    st_nxt         = st_r;
    n_nxt          = n_r;
    used_nxt       = used_r;
    lens_we        = 1'b0;
    lens_wa        = n_r[4:0];
    lens_wd        = req.len;
    line_start_nxt = line_start_r;
    word_start_nxt = word_start_r;
    final_nxt      = final_r;
    add_pend_nxt   = add_pend_r;
    te_pend_nxt    = te_pend_r;
    pend_len_nxt   = pend_len_r;
    div_cnt_nxt    = div_cnt_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    dvs_nxt        = dvs_r;
    q_nxt          = q_r;
    r_nxt          = r_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    k_nxt          = k_r;
    crem_nxt       = crem_r;
    grem_nxt       = grem_r;
    rd_ptr_nxt     = rd_ptr_r;
    req_take       = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = word_start_r + {1'b0, req.idx};
    rd_en          = 1'b0;
    s1_valid_nxt   = s1_valid_r;
    s1_char_nxt    = s1_char_r;
    s1_bidx_nxt    = s1_bidx_r;
    s1_last_nxt    = s1_last_r;
    s1_final_nxt   = s1_final_r;
    if (!stall) begin
      s1_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (req_valid) begin
          req_take = 1'b1;
          wr_en    = req.keep;
          if (req.wend) begin
            word_start_nxt = word_start_r + req.len;
            if (fit_fail) begin
              // Flush the pending line first, then place this word.
              pend_len_nxt = req.len;
              add_pend_nxt = 1'b1;
              te_pend_nxt  = req.tend;
              final_nxt    = 1'b0;
              if (n_r > 6'd1) begin
                dq_nxt      = spare_c[5:0];
                rem_nxt     = 6'd0;
                dvs_nxt     = 5'(n_r - 6'd1);
                div_cnt_nxt = 3'd0;
                st_nxt      = ST_DIV;
              end else begin
                q_nxt  = 6'd0;
                r_nxt  = 5'd0;
                st_nxt = ST_START;
              end
            end else begin
              lens_we  = 1'b1;
              used_nxt = (n_r != 6'd0) ? used_r + 7'd1 + req.len : req.len;
              n_nxt    = n_r + 6'd1;
              if (req.tend) begin
                final_nxt = 1'b1;
                st_nxt    = ST_START;
              end
            end
          end
        end
      end

      ST_DIV: begin
        // One quotient bit per cycle.
        rem_nxt     = q_bit ? rem_sh - {1'b0, dvs_r} : rem_sh;
        dq_nxt      = {dq_r[4:0], q_bit};
        div_cnt_nxt = div_cnt_r + 3'd1;
        if (div_cnt_r == 3'd5) begin
          q_nxt  = {dq_r[4:0], q_bit};
          r_nxt  = rem_nxt[4:0];
          st_nxt = ST_START;
        end
      end

      ST_START: begin
        len_nxt    = len_line_c;
        pos_nxt    = 7'd0;
        k_nxt      = 6'd0;
        crem_nxt   = lens_r[0];
        grem_nxt   = 7'd0;
        rd_ptr_nxt = line_start_r;
        st_nxt     = ST_EMIT;
      end

      ST_EMIT: begin
        if (!stall) begin
          // One output byte per cycle while not stalled: word character, gap space or padding.
          if (is_char) begin
            rd_en      = 1'b1;
            rd_ptr_nxt = rd_ptr_r + 1'b1;
            crem_nxt   = crem_r - 7'd1;
            if ((crem_r == 7'd1) && (k_inc < n_r)) begin
              grem_nxt = gap_c;
            end
          end else if (grem_r != 7'd0) begin
            grem_nxt = grem_r - 7'd1;
            if (grem_r == 7'd1) begin
              crem_nxt = lens_r[k_inc[4:0]];
              k_nxt    = k_inc;
            end
          end
          pos_nxt      = pos_r + 7'd1;
          s1_valid_nxt = 1'b1;
          s1_char_nxt  = is_char;
          s1_bidx_nxt  = pos_r[2:0];
          s1_last_nxt  = last_slot;
          s1_final_nxt = final_r;
          if (last_slot) begin
            // Line finished: clear it and resume any pending work.
            n_nxt          = 6'd0;
            used_nxt       = 7'd0;
            line_start_nxt = rd_ptr_nxt;
            st_nxt         = ST_IDLE;
            if (add_pend_r) begin
              add_pend_nxt = 1'b0;
              lens_we      = 1'b1;
              lens_wa      = 5'd0;
              lens_wd      = pend_len_r;
              n_nxt        = 6'd1;
              used_nxt     = pend_len_r;
              if (te_pend_r) begin
                te_pend_nxt = 1'b0;
                final_nxt   = 1'b1;
                st_nxt      = ST_START;
              end
            end
          end
        end
      end

      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Chunk assembly and the output register.
  always_comb begin
    byte_c    = s1_char_r ? rd_data : tfj_pkg::SPACE_CHAR;
    chunk_nxt = chunk_r;
    ov_nxt    = ov_r && !out_take;
    oc_nxt    = oc_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    ot_nxt    = ot_r;
    if (s1_valid_r && !stall) begin
      chunk_nxt = ((s1_bidx_r == 3'd0) ? 64'd0 : chunk_r)
                | ({56'd0, byte_c} << {s1_bidx_r, 3'b000});
      if (s1_done) begin
        ov_nxt = 1'b1;
        oc_nxt = chunk_nxt;
        ob_nxt = {1'b0, s1_bidx_r} + 4'd1;
        ol_nxt = s1_last_r;
        ot_nxt = s1_last_r && s1_final_r;
      end
    end
  end

  // Word length table.
  always_ff @(posedge clk) begin
    if (lens_we) begin
      lens_r[lens_wa] <= lens_wd;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pend_len_r  <= pend_len_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    dvs_r       <= dvs_nxt;
    q_r         <= q_nxt;
    r_r         <= r_nxt;
    len_r       <= len_nxt;
    pos_r       <= pos_nxt;
    k_r         <= k_nxt;
    crem_r      <= crem_nxt;
    grem_r      <= grem_nxt;
    rd_ptr_r    <= rd_ptr_nxt;
    s1_char_r   <= s1_char_nxt;
    s1_bidx_r   <= s1_bidx_nxt;
    s1_last_r   <= s1_last_nxt;
    s1_final_r  <= s1_final_nxt;
    chunk_r     <= chunk_nxt;
    oc_r        <= oc_nxt;
    ob_r        <= ob_nxt;
    ol_r        <= ol_nxt;
    ot_r        <= ot_nxt;
    div_cnt_r   <= div_cnt_nxt;
    final_r     <= final_nxt;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      n_r          <= 6'd0;
      used_r       <= 7'd0;
      line_start_r <= '0;
      word_start_r <= '0;
      add_pend_r   <= 1'b0;
      te_pend_r    <= 1'b0;
      s1_valid_r   <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      n_r          <= n_nxt;
      used_r       <= used_nxt;
      line_start_r <= line_start_nxt;
      word_start_r <= word_start_nxt;
      add_pend_r   <= add_pend_nxt;
      te_pend_r    <= te_pend_nxt;
      s1_valid_r   <= s1_valid_nxt;
      ov_r         <= ov_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign chunk       = oc_r;
  assign chunk_bytes = ob_r;
  assign line_end    = ol_r;
  assign text_done   = ot_r;

endmodule

// ===== hdl/text_full_justify_core.sv =====
// Full text justification into fixed-width lines.
//
// Input queue side: one character per request on in_char_code, with
// in_word_end on the last character of a word and in_text_end on the last
// character of the text. A request is taken when push is high and full low.
// Result queue side: chunks of up to eight characters, first character in
// the low byte; out_line_end marks the last chunk of a line and
// out_text_done the last chunk of the text. A chunk is taken when pop is
// high and empty low. cfg_wr_en writes the line width from cfg_wr_data.
//
// The back end takes characters only while no line is being written out. A
// two-entry request queue takes two more characters while a line is written
// out; after that, full stays high until the line is done. Flushing a line
// sets up the walker and then emits each output byte; when a line that is
// not the last of the text has two or more words, the spare-space division
// comes first. Each byte passes the chunk assembly stage and the output
// register before its chunk appears.
// A stalled receiver holds the chunk in the output register. The walker
// then halts, and the request queue fills up and raises full.
// Reset empties both queues, clears the pending line and sets the width to
// 16; the character buffer needs no clearing.
module text_full_justify_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_code,
  input  logic        in_word_end,
  input  logic        in_text_end,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_chunk,
  output logic [3:0]  out_chunk_bytes,
  output logic        out_line_end,
  output logic        out_text_done,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  logic [6:0]        line_width_r;
  logic [6:0]        width;
  logic              accept;
  tfj_pkg::tfj_req_t front_req;
  tfj_pkg::tfj_req_t head_req;
  logic              q_valid;
  logic              q_take;
  logic              out_valid;

  // Line width register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= tfj_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      line_width_r <= cfg_wr_data;
    end
  end

  assign width  = tfj_pkg::eff_width(line_width_r);
  assign accept = push && !full;
  assign empty  = !out_valid;

  tfj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .width     (width),
    .accept    (accept),
    .char_code (in_char_code),
    .word_end  (in_word_end),
    .text_end  (in_text_end),
    .req       (front_req)
  );

  tfj_req_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (front_req),
    .full     (full),
    .valid    (q_valid),
    .head     (head_req),
    .take     (q_take)
  );

  tfj_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .width       (width),
    .req_valid   (q_valid),
    .req         (head_req),
    .req_take    (q_take),
    .out_valid   (out_valid),
    .out_take    (pop),
    .chunk       (out_chunk),
    .chunk_bytes (out_chunk_bytes),
    .line_end    (out_line_end),
    .text_done   (out_text_done)
  );

endmodule

// ===== hdl/tfj_checker.sv =====
module tfj_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [63:0] out_chunk,
  input logic [3:0]  out_chunk_bytes,
  input logic        out_line_end,
  input logic        out_text_done
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Reset leaves room for a request.
  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("request queue full after reset");

  // Only the last chunk of a line may be short.
  a_full_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_line_end) |-> (out_chunk_bytes == 4'd8))
    else $error("short chunk in the middle of a line");

  // The end of the text is always the end of a line.
  a_done_line: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_text_done) |-> out_line_end)
    else $error("text end without line end");

  // A waiting result holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_chunk) && $stable(out_chunk_bytes)))
    else $error("waiting result changed");

endmodule

bind text_full_justify_core tfj_checker u_tfj_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_chunk       (out_chunk),
  .out_chunk_bytes (out_chunk_bytes),
  .out_line_end    (out_line_end),
  .out_text_done   (out_text_done)
);
